// ===== rtl/core/lobt_pkg.sv =====
// Shared types and codes for the limit order book table.
// Used by lobt_unit, the top level and the checker; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package lobt_pkg;

   // Fixed field widths of the item formats
   localparam int ID_W    = 32;
   localparam int PRICE_W = 20;
   localparam int QTY_W   = 16;
   localparam int COUNT_W = 7;

   typedef enum logic [0:0] {
      OP_ADD    = 1'b0,
      OP_CANCEL = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_BAD_QTY   = 2'd1,
      ST_NOT_FOUND = 2'd2,
      ST_FULL      = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_ADD,
      S_FIND,
      S_SHIFT,
      S_RESP
   } state_type;

   typedef struct packed {
      op_type                    op;
      logic [ID_W-1:0]           order_key;
      logic [PRICE_W-1:0]        price_ticks;
      logic signed [QTY_W-1:0]   quantity;
   } req_type;

   typedef struct packed {
      status_type                status;
      logic [PRICE_W-1:0]        best_price;
      logic                      book_empty;
      logic [COUNT_W-1:0]        order_count;
   } rsp_type;

   // Outcome of one pass through the shared compare unit
   typedef struct packed {
      logic                      take_hit;
      logic [PRICE_W-1:0]        max_price;
   } unit_res_type;

endpackage

`default_nettype wire

// ===== rtl/core/lobt_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

module lobt_ram #(
   parameter int WIDTH = 52,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== rtl/core/lobt_unit.sv =====
// Shared compare unit: id match, lowest-price hit selection and running max.
// Depends on lobt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lobt_unit (
   input  wire logic [lobt_pkg::ID_W-1:0]    ent_id,
   input  wire logic [lobt_pkg::PRICE_W-1:0] ent_price,
   input  wire logic [lobt_pkg::ID_W-1:0]    key_id,
   input  wire logic                         hit_found,
   input  wire logic [lobt_pkg::PRICE_W-1:0] hit_price,
   input  wire logic [lobt_pkg::PRICE_W-1:0] acc_max,
   output lobt_pkg::unit_res_type            res
);

   // Strictly lower price replaces the hit, so the oldest wins a tie
   always_comb begin
      res.take_hit  = (ent_id == key_id) && (!hit_found || (ent_price < hit_price));
      res.max_price = (ent_price > acc_max) ? ent_price : acc_max;
   end

endmodule

`default_nettype wire

// ===== rtl/core/limit_order_book_table_top.sv =====
// Top level of the limit order book table: sequencer, entry RAM and compare unit.
// Depends on lobt_pkg, lobt_ram and lobt_unit.
`timescale 1ns / 1ps
`default_nettype none

// Bounded table of resting orders (id, price) in arrival order, one item at a
// time. An add passes from S_ADD to S_RESP. A cancel scans every resting order
// for the id and removes the lowest-priced match that it finds: the table lives
// in a RAM with one read port, so the id search reads one entry a cycle, then
// the compaction moves the later entries down one a cycle while it rebuilds
// the best price. req_stall is high from acceptance until the result is loaded
// into the output register; a waiting result does not block the next item,
// only the one after it.
// The RAM needs no clearing after reset: only entries below the count are read.
module limit_order_book_table_top #(
   parameter int TABLE_DEPTH = 64,
   parameter int PRICE_BITS  = 20
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire lobt_pkg::req_type req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output lobt_pkg::rsp_type      rsp_data
);

   localparam int IdxBits   = $clog2(TABLE_DEPTH);
   localparam int CntBits   = $clog2(TABLE_DEPTH + 1);
   localparam int StoreBits = (PRICE_BITS < lobt_pkg::PRICE_W) ? PRICE_BITS
                                                               : lobt_pkg::PRICE_W;
   localparam int EntBits   = lobt_pkg::ID_W + StoreBits;

   lobt_pkg::state_type               state_ff, state_in;
   lobt_pkg::op_type                  op_ff, op_in;
   logic [lobt_pkg::ID_W-1:0]         id_ff, id_in;
   logic [StoreBits-1:0]              price_ff, price_in;
   logic                              qty_bad_ff, qty_bad_in;
   logic [CntBits-1:0]                count_ff, count_in;
   logic [lobt_pkg::PRICE_W-1:0]      best_ff, best_in;
   lobt_pkg::status_type              status_ff, status_in;
   logic [CntBits-1:0]                rd_ff, rd_in;
   logic                              vld_ff, vld_in;
   logic [IdxBits-1:0]                idx_ff, idx_in;
   logic                              found_ff, found_in;
   logic [IdxBits-1:0]                hit_idx_ff, hit_idx_in;
   logic [lobt_pkg::PRICE_W-1:0]      hit_price_ff, hit_price_in;
   logic [lobt_pkg::PRICE_W-1:0]      run_max_ff, run_max_in;
   logic [lobt_pkg::PRICE_W-1:0]      pre_max_ff, pre_max_in;
   logic [lobt_pkg::PRICE_W-1:0]      post_max_ff, post_max_in;
   logic                              rsp_valid_ff, rsp_valid_in;
   lobt_pkg::rsp_type                 rsp_data_ff, rsp_data_in;

   logic                              ram_wr_en;
   logic [IdxBits-1:0]                ram_wr_addr;
   logic [EntBits-1:0]                ram_wr_data;
   logic                              ram_rd_en;
   logic [EntBits-1:0]                ram_rd_data;
   logic [lobt_pkg::ID_W-1:0]         rd_id;
   logic [lobt_pkg::PRICE_W-1:0]      rd_price;

   logic [lobt_pkg::PRICE_W-1:0]      unit_ent_price;
   logic [lobt_pkg::PRICE_W-1:0]      unit_acc;
   lobt_pkg::unit_res_type            unit_res;

   logic                              scan_done;
   logic                              rsp_free;

   // Entry storage: {id, price}
   lobt_ram #(
      .WIDTH (EntBits),
      .DEPTH (TABLE_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (rd_ff[IdxBits-1:0]),
      .rd_data (ram_rd_data)
   );

   assign rd_id    = ram_rd_data[EntBits-1 -: lobt_pkg::ID_W];
   assign rd_price = lobt_pkg::PRICE_W'(ram_rd_data[StoreBits-1:0]);

   // Compare unit operand select
   always_comb begin
      unit_ent_price = rd_price;
      unit_acc       = run_max_ff;
      unique case (state_ff)
         lobt_pkg::S_ADD: begin
            unit_ent_price = lobt_pkg::PRICE_W'(price_ff);
            unit_acc       = best_ff;
         end
         lobt_pkg::S_SHIFT: begin
            // after the last move the unit merges the two partial maxima
            unit_ent_price = vld_ff ? rd_price : pre_max_ff;
            unit_acc       = post_max_ff;
         end
         default: begin
         end
      endcase
   end

   lobt_unit u_unit (
      .ent_id    (rd_id),
      .ent_price (unit_ent_price),
      .key_id    (id_ff),
      .hit_found (found_ff),
      .hit_price (hit_price_ff),
      .acc_max   (unit_acc),
      .res       (unit_res)
   );

   assign scan_done = (rd_ff >= count_ff) && !vld_ff;
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;

   // Sequencer: next state and datapath updates
   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      id_in        = id_ff;
      price_in     = price_ff;
      qty_bad_in   = qty_bad_ff;
      count_in     = count_ff;
      best_in      = best_ff;
      status_in    = status_ff;
      rd_in        = rd_ff;
      found_in     = found_ff;
      hit_idx_in   = hit_idx_ff;
      hit_price_in = hit_price_ff;
      run_max_in   = run_max_ff;
      pre_max_in   = pre_max_ff;
      post_max_in  = post_max_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      ram_wr_en    = 1'b0;
      ram_wr_addr  = count_ff[IdxBits-1:0];
      ram_wr_data  = {id_ff, price_ff};

      // one RAM read issued per cycle while scanning
      ram_rd_en = ((state_ff == lobt_pkg::S_FIND) || (state_ff == lobt_pkg::S_SHIFT))
                  && (rd_ff < count_ff);
      vld_in    = ram_rd_en;
      idx_in    = rd_ff[IdxBits-1:0];
      if (ram_rd_en) begin
         rd_in = rd_ff + CntBits'(1);
      end

      unique case (state_ff)
         lobt_pkg::S_IDLE: begin
            if (req_valid) begin
               op_in       = req_data.op;
               id_in       = req_data.order_key;
               price_in    = req_data.price_ticks[StoreBits-1:0];
               qty_bad_in  = (req_data.quantity == '0) || req_data.quantity[lobt_pkg::QTY_W-1];
               rd_in       = '0;
               found_in    = 1'b0;
               run_max_in  = '0;
               pre_max_in  = '0;
               state_in    = (req_data.op == lobt_pkg::OP_ADD) ? lobt_pkg::S_ADD
                                                               : lobt_pkg::S_FIND;
            end
         end

         lobt_pkg::S_ADD: begin
            priority if (qty_bad_ff) begin
               status_in = lobt_pkg::ST_BAD_QTY;
            end else if (count_ff == CntBits'(TABLE_DEPTH)) begin
               status_in = lobt_pkg::ST_FULL;
            end else begin
               ram_wr_en = 1'b1;
               count_in  = count_ff + CntBits'(1);
               best_in   = unit_res.max_price;
               status_in = lobt_pkg::ST_OK;
            end
            state_in = lobt_pkg::S_RESP;
         end

         // search for the lowest-priced matching entry
         lobt_pkg::S_FIND: begin
            if (vld_ff) begin
               if (unit_res.take_hit) begin
                  found_in     = 1'b1;
                  hit_idx_in   = idx_ff;
                  hit_price_in = rd_price;
                  pre_max_in   = run_max_ff;
               end
               run_max_in = unit_res.max_price;
            end
            if (scan_done) begin
               if (found_ff) begin
                  rd_in       = CntBits'(hit_idx_ff) + CntBits'(1);
                  post_max_in = '0;
                  state_in    = lobt_pkg::S_SHIFT;
               end else begin
                  status_in = lobt_pkg::ST_NOT_FOUND;
                  state_in  = lobt_pkg::S_RESP;
               end
            end
         end

         // move later entries down one place, max over the moved ones
         lobt_pkg::S_SHIFT: begin
            if (vld_ff) begin
               ram_wr_en   = 1'b1;
               ram_wr_addr = idx_ff - IdxBits'(1);
               ram_wr_data = ram_rd_data;
               post_max_in = unit_res.max_price;
            end
            if (scan_done) begin
               count_in  = count_ff - CntBits'(1);
               best_in   = unit_res.max_price;
               status_in = lobt_pkg::ST_OK;
               state_in  = lobt_pkg::S_RESP;
            end
         end

         lobt_pkg::S_RESP: begin
            if (rsp_free) begin
               rsp_valid_in            = 1'b1;
               rsp_data_in.status      = status_ff;
               rsp_data_in.best_price  = best_ff;
               rsp_data_in.book_empty  = (count_ff == '0);
               rsp_data_in.order_count = lobt_pkg::COUNT_W'(count_ff);
               state_in                = lobt_pkg::S_IDLE;
            end
         end

         default: begin
            state_in = lobt_pkg::S_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lobt_pkg::S_IDLE;
         count_ff     <= '0;
         best_ff      <= '0;
         vld_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         best_ff      <= best_in;
         vld_ff       <= vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      id_ff        <= id_in;
      price_ff     <= price_in;
      qty_bad_ff   <= qty_bad_in;
      status_ff    <= status_in;
      rd_ff        <= rd_in;
      idx_ff       <= idx_in;
      found_ff     <= found_in;
      hit_idx_ff   <= hit_idx_in;
      hit_price_ff <= hit_price_in;
      run_max_ff   <= run_max_in;
      pre_max_ff   <= pre_max_in;
      post_max_ff  <= post_max_in;
      rsp_data_ff  <= rsp_data_in;
   end

   assign req_stall = (state_ff != lobt_pkg::S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

// ===== rtl/core/lobt_chk.sv =====
// Port-level checker for the limit order book table, bound to the top level.
// Depends on lobt_pkg and limit_order_book_table_top.
`timescale 1ns / 1ps
`default_nettype none

module lobt_chk (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              req_valid,
   input wire logic              req_stall,
   input wire lobt_pkg::req_type req_data,
   input wire logic              rsp_valid,
   input wire logic              rsp_stall,
   input wire lobt_pkg::rsp_type rsp_data
);

   // A stalled result item holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("result item changed while stalled");

   // One item at a time: an accepted item makes the block busy
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("block not busy after accepting an item");

   // An empty book reports no best price and no orders
   a_empty_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.book_empty |->
         (rsp_data.best_price == '0) && (rsp_data.order_count == '0))
      else $error("empty book with nonzero best price or count");

   // No result item can rise in the cycle right after an item is accepted
   a_no_result_while_idle_req: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> !$rose(rsp_valid))
      else $error("result appeared one cycle after accept");

endmodule

bind limit_order_book_table_top lobt_chk u_lobt_chk (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

`default_nettype wire
